### src/matting_alpha_estimator_unit_defines.svh
// Assertion macros for the matting alpha estimator.
// Depends on clk_i and rst_ni in the module that uses them.
`ifndef MATTING_ALPHA_ESTIMATOR_UNIT_DEFINES_SVH
`define MATTING_ALPHA_ESTIMATOR_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define MAEA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define MAEA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/maea_pkg.sv
// Shared constants for the matting alpha estimator.
// No dependencies.
package maea_pkg;
  localparam int unsigned COLOUR_W = 24;
  localparam int unsigned ALPHA_W = 8;
  localparam int unsigned NUM_CHAN = 3;
  localparam logic [ALPHA_W-1:0] ALPHA_FULL = 8'd255;
endpackage

### src/maea_div.sv
// Pipelined restoring divider, one quotient bit per stage, shared denominator.
// Caller guarantees each quotient fits in QW bits. Standalone, no package use.
module maea_div #(
  parameter int unsigned LANES = 3,
  parameter int unsigned NW = 26,
  parameter int unsigned DW = 18,
  parameter int unsigned QW = 9,
  parameter int unsigned SW = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [LANES-1:0][NW-1:0]    num_i,
  input  logic [DW-1:0]               den_i,
  input  logic [SW-1:0]               side_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [LANES-1:0][QW-1:0]    quot_o,
  output logic [SW-1:0]               side_o
);
  localparam int unsigned XW = NW + QW;

  logic [QW-1:0]                     v_q;
  logic [QW:0]                       en;
  logic [QW-1:0][LANES-1:0][NW-1:0]  r_q, r_d;
  logic [QW-1:0][LANES-1:0][QW-1:0]  q_q, q_d;
  logic [QW-1:0][DW-1:0]             d_q;
  logic [QW-1:0][SW-1:0]             s_q;

  assign en[QW] = out_ready_i;

  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int unsigned K = QW - 1 - s;
    logic                       v_in;
    logic [LANES-1:0][NW-1:0]   r_in;
    logic [LANES-1:0][QW-1:0]   q_in;
    logic [DW-1:0]              d_in;
    logic [SW-1:0]              s_in;

    if (s == 0) begin : g_first
      assign v_in = in_valid_i;
      assign r_in = num_i;
      assign q_in = '0;
      assign d_in = den_i;
      assign s_in = side_i;
    end else begin : g_next
      assign v_in = v_q[s-1];
      assign r_in = r_q[s-1];
      assign q_in = q_q[s-1];
      assign d_in = d_q[s-1];
      assign s_in = s_q[s-1];
    end

    assign en[s] = !v_q[s] || en[s+1];

    always_comb begin
      logic [XW-1:0] dsh;
      logic          ge;
      dsh = XW'(d_in) << K;
      for (int l = 0; l < LANES; l++) begin
        ge = XW'(r_in[l]) >= dsh;
        r_d[s][l] = ge ? NW'(XW'(r_in[l]) - dsh) : r_in[l];
        q_d[s][l] = q_in[l];
        q_d[s][l][K] = ge;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en[s]) begin
        v_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[s] && v_in) begin
        r_q[s] <= r_d[s];
        q_q[s] <= q_d[s];
        d_q[s] <= d_in;
        s_q[s] <= s_in;
      end
    end
  end

  assign in_ready_o = en[0];
  assign out_valid_o = v_q[QW-1];
  assign quot_o = q_q[QW-1];
  assign side_o = s_q[QW-1];
endmodule

### src/matting_alpha_estimator_unit.sv
// Knockout-style alpha estimator: refines one color sample, then computes alpha.
// Depends on maea_pkg, maea_div and matting_alpha_estimator_unit_defines.svh.
//
// One pixel per cycle while the output is ready, fully pipelined: four stages of
// difference, product, sum and numerator work, one refine-divider stage per
// quotient bit, two stages of repack and alpha sums, then eight alpha-divider
// stages. Ready travels back stage by stage, so bubbles are filled while a
// result waits at the output.
`include "matting_alpha_estimator_unit_defines.svh"

module matting_alpha_estimator_unit import maea_pkg::*; #(
  parameter int unsigned CHANNEL_BITS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [COLOUR_W-1:0] fore_colour_i,
  input  logic [COLOUR_W-1:0] back_colour_i,
  input  logic [COLOUR_W-1:0] pixel_colour_i,
  input  logic                refine_background_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [ALPHA_W-1:0]  alpha_level_o,
  output logic [COLOUR_W-1:0] refined_colour_o
);
  localparam int unsigned CB  = CHANNEL_BITS;
  localparam int unsigned PW  = 2 * CB;
  localparam int unsigned SMW = 2 * CB + 2;
  localparam int unsigned NW1 = 3 * CB + 2;
  localparam int unsigned QW1 = CB + 1;
  localparam int unsigned AW  = CB + 2;
  localparam int unsigned NW2 = CB + 2 + ALPHA_W;
  localparam int unsigned SW1 = 3 * COLOUR_W + 2;
  localparam int unsigned SW2 = COLOUR_W + 1;

  function automatic logic [CB-1:0] chan(input logic [COLOUR_W-1:0] c, input int k);
    logic [3*CB+COLOUR_W-1:0] w;
    w = {{(3*CB){1'b0}}, c};
    return w[k*CB +: CB];
  endfunction

  function automatic logic [CB-1:0] absd(input logic [CB-1:0] a, input logic [CB-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  logic a_en, b_en, c_en, d_en, e_en, f_en;
  logic a_v_q, b_v_q, c_v_q, d_v_q, e_v_q, f_v_q;

  // stage A: sample differences
  logic [NUM_CHAN-1:0][CB-1:0] a_sr_q, a_sc_q;
  logic [COLOUR_W-1:0] a_fore_q, a_back_q, a_pix_q;
  logic                a_flag_q;
  // stage B: products
  logic [NUM_CHAN-1:0][PW-1:0] b_pd_q, b_pn_q;
  logic [NUM_CHAN-1:0][CB-1:0] b_sr_q;
  logic [COLOUR_W-1:0] b_fore_q, b_back_q, b_pix_q;
  logic                b_flag_q;
  // stage C: dot and norm
  logic [SMW-1:0]      c_dot_q, c_norm_q;
  logic [NUM_CHAN-1:0][CB-1:0] c_sr_q;
  logic [COLOUR_W-1:0] c_fore_q, c_back_q, c_pix_q;
  logic                c_flag_q;
  // stage D: projection numerators
  logic [NUM_CHAN-1:0][NW1-1:0] d_num_q;
  logic [SMW-1:0]      d_norm_q;
  logic [COLOUR_W-1:0] d_fore_q, d_back_q, d_pix_q;
  logic                d_flag_q;
  // stage E: refined sample
  logic [COLOUR_W-1:0] e_fore_q, e_back_q, e_pix_q, e_ref_q;
  // stage F: alpha terms
  logic [NW2-1:0]      f_num_q;
  logic [AW-1:0]       f_den_q;
  logic                f_sat_q;
  logic [COLOUR_W-1:0] f_ref_q;

  logic                         div1_in_ready, div1_out_valid;
  logic [NUM_CHAN-1:0][QW1-1:0] div1_quot;
  logic [SW1-1:0]               div1_side;
  logic                         div2_in_ready;
  logic [0:0][ALPHA_W-1:0]      div2_quot;
  logic [SW2-1:0]               div2_side;

  assign f_en = !f_v_q || div2_in_ready;
  assign e_en = !e_v_q || f_en;
  assign d_en = !d_v_q || div1_in_ready;
  assign c_en = !c_v_q || d_en;
  assign b_en = !b_v_q || c_en;
  assign a_en = !a_v_q || b_en;
  assign in_ready_o = a_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
      d_v_q <= 1'b0;
      e_v_q <= 1'b0;
      f_v_q <= 1'b0;
    end else begin
      if (a_en) a_v_q <= in_valid_i;
      if (b_en) b_v_q <= a_v_q;
      if (c_en) c_v_q <= b_v_q;
      if (d_en) d_v_q <= c_v_q;
      if (e_en) e_v_q <= div1_out_valid;
      if (f_en) f_v_q <= e_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    logic [COLOUR_W-1:0] tgt, oth;
    tgt = refine_background_i ? back_colour_i : fore_colour_i;
    oth = refine_background_i ? fore_colour_i : back_colour_i;
    if (a_en && in_valid_i) begin
      for (int i = 0; i < NUM_CHAN; i++) begin
        a_sr_q[i] <= absd(chan(oth, NUM_CHAN-1-i), chan(tgt, NUM_CHAN-1-i));
        a_sc_q[i] <= absd(chan(pixel_colour_i, NUM_CHAN-1-i), chan(tgt, NUM_CHAN-1-i));
      end
      a_fore_q <= fore_colour_i;
      a_back_q <= back_colour_i;
      a_pix_q  <= pixel_colour_i;
      a_flag_q <= refine_background_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_en && a_v_q) begin
      for (int i = 0; i < NUM_CHAN; i++) begin
        b_pd_q[i] <= PW'(a_sr_q[i]) * PW'(a_sc_q[i]);
        b_pn_q[i] <= PW'(a_sr_q[i]) * PW'(a_sr_q[i]);
      end
      b_sr_q   <= a_sr_q;
      b_fore_q <= a_fore_q;
      b_back_q <= a_back_q;
      b_pix_q  <= a_pix_q;
      b_flag_q <= a_flag_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_en && b_v_q) begin
      c_dot_q  <= SMW'(b_pd_q[0]) + SMW'(b_pd_q[1]) + SMW'(b_pd_q[2]);
      c_norm_q <= SMW'(b_pn_q[0]) + SMW'(b_pn_q[1]) + SMW'(b_pn_q[2]);
      c_sr_q   <= b_sr_q;
      c_fore_q <= b_fore_q;
      c_back_q <= b_back_q;
      c_pix_q  <= b_pix_q;
      c_flag_q <= b_flag_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (d_en && c_v_q) begin
      for (int i = 0; i < NUM_CHAN; i++) begin
        d_num_q[i] <= NW1'(c_dot_q) * NW1'(c_sr_q[i]);
      end
      d_norm_q <= c_norm_q;
      d_fore_q <= c_fore_q;
      d_back_q <= c_back_q;
      d_pix_q  <= c_pix_q;
      d_flag_q <= c_flag_q;
    end
  end

  maea_div #(
    .LANES(NUM_CHAN), .NW(NW1), .DW(SMW), .QW(QW1), .SW(SW1)
  ) u_refine_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (d_v_q),
    .in_ready_o  (div1_in_ready),
    .num_i       (d_num_q),
    .den_i       (d_norm_q),
    .side_i      ({d_flag_q, (d_norm_q == '0), d_fore_q, d_back_q, d_pix_q}),
    .out_valid_o (div1_out_valid),
    .out_ready_i (e_en),
    .quot_o      (div1_quot),
    .side_o      (div1_side)
  );

  always_ff @(posedge clk_i) begin
    logic                flag, nz;
    logic [COLOUR_W-1:0] fore, back, pix, tgt, packed_c;
    logic [NUM_CHAN-1:0][COLOUR_W-1:0] v;
    {flag, nz, fore, back, pix} = div1_side;
    tgt = flag ? back : fore;
    for (int i = 0; i < NUM_CHAN; i++) begin
      v[i] = COLOUR_W'(chan(pix, NUM_CHAN-1-i)) - COLOUR_W'(div1_quot[i]);
    end
    packed_c = (v[0] << (2 * CB)) + (v[1] << CB) + v[2];
    if (e_en && div1_out_valid) begin
      e_ref_q  <= nz ? tgt : packed_c;
      e_fore_q <= flag ? fore : (nz ? tgt : packed_c);
      e_back_q <= flag ? (nz ? tgt : packed_c) : back;
      e_pix_q  <= pix;
    end
  end

  always_ff @(posedge clk_i) begin
    logic [AW-1:0] num, den;
    logic [CB-1:0] sb;
    num = '0;
    den = '0;
    for (int i = 0; i < NUM_CHAN; i++) begin
      sb = absd(chan(e_fore_q, i), chan(e_back_q, i));
      if (sb != '0) num = num + AW'(absd(chan(e_pix_q, i), chan(e_back_q, i)));
      den = den + AW'(sb);
    end
    if (f_en && e_v_q) begin
      f_num_q <= (NW2'(num) << ALPHA_W) - NW2'(num);
      f_den_q <= den;
      f_sat_q <= (den == '0) || (num >= den);
      f_ref_q <= e_ref_q;
    end
  end

  maea_div #(
    .LANES(1), .NW(NW2), .DW(AW), .QW(ALPHA_W), .SW(SW2)
  ) u_alpha_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (f_v_q),
    .in_ready_o  (div2_in_ready),
    .num_i       (f_num_q),
    .den_i       (f_den_q),
    .side_i      ({f_sat_q, f_ref_q}),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .quot_o      (div2_quot),
    .side_o      (div2_side)
  );

  assign alpha_level_o    = div2_side[COLOUR_W] ? ALPHA_FULL : div2_quot[0];
  assign refined_colour_o = div2_side[COLOUR_W-1:0];

  `MAEA_ASSERT_IMPL(a_stall_from_output, !in_ready_o, out_valid_o, "input stalled with no result pending")
  `MAEA_ASSERT_IMPL(a_alpha_below_full, out_valid_o && !div2_side[COLOUR_W], div2_quot[0] != ALPHA_FULL, "unsaturated alpha reached full scale")
  `MAEA_ASSERT_NEXT(a_accept_fills_a, in_valid_i && in_ready_o, a_v_q, "accepted transfer not in first stage")
endmodule

### verif/tb_top.sv
// Self-checking testbench for matting_alpha_estimator_unit at the default channel width.
// Depends on maea_pkg and the unit RTL; predicts refined color and alpha per pixel.
module tb_top import maea_pkg::*; ();

  localparam int unsigned CB = 8;
  localparam int unsigned LIMIT = 400000;

  typedef struct packed {
    logic [COLOUR_W-1:0] fore;
    logic [COLOUR_W-1:0] back;
    logic [COLOUR_W-1:0] pixel;
    logic                refine_bg;
  } pixel_item_t;

  typedef struct packed {
    logic [ALPHA_W-1:0]  alpha;
    logic [COLOUR_W-1:0] refined;
  } matte_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [COLOUR_W-1:0] fore_colour_i = '0;
  logic [COLOUR_W-1:0] back_colour_i = '0;
  logic [COLOUR_W-1:0] pixel_colour_i = '0;
  logic                refine_background_i = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [ALPHA_W-1:0]  alpha_level_o;
  logic [COLOUR_W-1:0] refined_colour_o;

  pixel_item_t pending_q[$];
  matte_t      matte_q[$];
  int          errors = 0;
  int          cycles = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          stim_done = 1'b0;

  matting_alpha_estimator_unit #(.CHANNEL_BITS(CB)) uut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic logic [7:0] chan(logic [23:0] c, int k);
    return c[CB*(2-k) +: CB];
  endfunction

  function automatic longint absd(longint a, longint b);
    return a > b ? a - b : b - a;
  endfunction

  function automatic logic [23:0] refine_sample(logic [23:0] tgt, logic [23:0] oth,
                                                logic [23:0] pix);
    longint sr[3];
    longint dot;
    longint norm;
    logic [31:0] v[3];
    logic [31:0] packed_c;
    dot = 0;
    norm = 0;
    for (int k = 0; k < 3; k++) begin
      sr[k] = absd(chan(oth, k), chan(tgt, k));
      dot += sr[k] * absd(chan(pix, k), chan(tgt, k));
      norm += sr[k] * sr[k];
    end
    if (norm == 0) return tgt;
    for (int k = 0; k < 3; k++) v[k] = 32'(chan(pix, k)) - 32'((dot * sr[k]) / norm);
    packed_c = (v[0] << (2 * CB)) + (v[1] << CB) + v[2];
    return packed_c[23:0];
  endfunction

  function automatic logic [7:0] alpha_of(logic [23:0] f, logic [23:0] b, logic [23:0] p);
    longint num;
    longint den;
    longint sb;
    num = 0;
    den = 0;
    for (int k = 0; k < 3; k++) begin
      sb = absd(chan(f, k), chan(b, k));
      if (sb != 0) num += absd(chan(p, k), chan(b, k));
      den += sb;
    end
    if (den == 0 || num >= den) return ALPHA_FULL;
    return 8'((255 * num) / den);
  endfunction

  function automatic matte_t predict_matte(pixel_item_t it);
    matte_t m;
    if (it.refine_bg) begin
      m.refined = refine_sample(it.back, it.fore, it.pixel);
      m.alpha = alpha_of(it.fore, m.refined, it.pixel);
    end else begin
      m.refined = refine_sample(it.fore, it.back, it.pixel);
      m.alpha = alpha_of(m.refined, it.back, it.pixel);
    end
    return m;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycles);
  endtask

  function automatic logic [23:0] rand_colour();
    case ($urandom_range(0, 5))
      0: return 24'h000000;
      1: return 24'hffffff;
      2: return {$urandom_range(0, 1) ? 8'hff : 8'h00, $urandom_range(0, 1) ? 8'hff : 8'h00,
                 $urandom_range(0, 1) ? 8'hff : 8'h00};
      default: return 24'($urandom());
    endcase
  endfunction

  task automatic push(logic [23:0] f, logic [23:0] b, logic [23:0] p, logic r);
    pending_q.insert(pending_q.size(), '{fore: f, back: b, pixel: p, refine_bg: r});
  endtask

  // driver
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (in_valid_i && in_ready_o) begin
      matte_q.insert(matte_q.size(), predict_matte({fore_colour_i, back_colour_i,
                                                    pixel_colour_i, refine_background_i}));
    end
    if (rst_ni && (!in_valid_i || in_ready_o)) begin
      if (pending_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        pixel_item_t it;
        it = pending_q.pop_front();
        in_valid_i <= 1'b1;
        fore_colour_i <= it.fore;
        back_colour_i <= it.back;
        pixel_colour_i <= it.pixel;
        refine_background_i <= it.refine_bg;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      if (matte_q.size() == 0) begin
        report("unexpected transfer", '0, '0);
      end else begin
        matte_t m;
        m = matte_q.pop_front();
        if (alpha_level_o !== m.alpha) begin
          report("alpha_level", 32'(alpha_level_o), 32'(m.alpha));
        end
        if (refined_colour_o !== m.refined) begin
          report("refined_colour", 32'(refined_colour_o), 32'(m.refined));
        end
      end
    end
    if (rst_ni) out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (cycles >= LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    // directed: extremes, both refine modes, zero sample difference, borrows, zero den
    push(24'h000000, 24'h000000, 24'h000000, 1'b0);
    push(24'h000000, 24'h000000, 24'hffffff, 1'b1);
    push(24'hffffff, 24'h000000, 24'hffffff, 1'b0);
    push(24'hffffff, 24'h000000, 24'h000000, 1'b1);
    push(24'hffffff, 24'h000000, 24'h808080, 1'b0);
    push(24'hffffff, 24'h000000, 24'h808080, 1'b1);
    push(24'h123456, 24'h123456, 24'habcdef, 1'b0);
    push(24'h123456, 24'h123456, 24'habcdef, 1'b1);
    push(24'hff0000, 24'h000000, 24'h00ff00, 1'b0);
    push(24'h0000ff, 24'h000000, 24'h0000ff, 1'b1);
    push(24'h000001, 24'h0000ff, 24'h000000, 1'b0);
    push(24'h00ff00, 24'h000000, 24'h000000, 1'b0);
    push(24'hff00ff, 24'h00ff00, 24'h0f0f0f, 1'b1);
    push(24'h808080, 24'h7f7f7f, 24'hffffff, 1'b0);
    push(24'h010101, 24'h000000, 24'hffffff, 1'b1);
    push(24'haaaaaa, 24'h555555, 24'h555555, 1'b0);
    push(24'h555555, 24'haaaaaa, 24'haaaaaa, 1'b1);
    for (int i = 0; i < 1300; i++) begin
      push(rand_colour(), rand_colour(), rand_colour(), 1'($urandom()));
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 56; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 56; end
        default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase
      repeat (300) @(posedge clk_i);
    end
    wait (pending_q.size() == 0 && !in_valid_i);
    wait (matte_q.size() == 0);
    repeat (40) @(posedge clk_i);
    if (errors == 0 && matte_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
